>>> sv/crc8r_pkg.sv
// Shared types, constants and the CRC-8 fold for the framed receiver.
// No dependencies; every other file except crc8r_ram refers to it by scoped names.
package crc8r_pkg;

    localparam int PAYLOAD_LEN = 32;
    localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam int POS_W       = 7;
    localparam int RAM_AW      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** RAM_AW;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CNT_W  = FIFO_AW + 1;

    typedef enum logic [1:0] {
        KIND_TAKEN  = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_FAIL   = 2'd2,
        KIND_GOOD   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_POLY  = 2'd1,
        CFG_INIT  = 2'd2
    } t_cfg_index;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_BURST = 1'b1
    } t_back_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] fail_total;
        logic       bank;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

>>> sv/crc8r_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crc8r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/crc8r_cmd_fifo.sv
// Short command queue between the frame front end and the result back end.
// Depends on crc8r_pkg.
module crc8r_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crc8r_pkg::t_cmd i_push_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output crc8r_pkg::t_cmd o_head,
    output logic            o_empty
);

    crc8r_pkg::t_cmd                       r_slot [crc8r_pkg::FIFO_DEPTH];
    logic [crc8r_pkg::FIFO_AW-1:0]         r_wr_ptr;
    logic [crc8r_pkg::FIFO_AW-1:0]         r_rd_ptr;
    logic [crc8r_pkg::FIFO_CNT_W-1:0]      r_count;

    assign o_full  = (r_count == crc8r_pkg::FIFO_CNT_W'(crc8r_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full command queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty command queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= crc8r_pkg::FIFO_CNT_W'(crc8r_pkg::FIFO_DEPTH))
        else $error("command queue count out of range");

endmodule

>>> sv/crc8r_front.sv
// Front end: config registers, frame tracking, CRC, payload writes and
// command generation. Depends on crc8r_pkg.
module crc8r_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [1:0]                   i_cfg_index,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         i_rx_valid,
    output logic                         o_rx_ready,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_ram_wr_en,
    output logic [crc8r_pkg::RAM_AW-1:0] o_ram_wr_addr,
    output logic [7:0]                   o_ram_wr_data,
    output logic                         o_push,
    output crc8r_pkg::t_cmd              o_push_cmd,
    input  logic                         i_fifo_full,
    input  logic                         i_burst_done
);

    localparam logic [crc8r_pkg::POS_W-1:0] POS_CRC =
        crc8r_pkg::POS_W'(crc8r_pkg::PAYLOAD_LEN + 1);

    logic [7:0]                  r_start_byte;
    logic [7:0]                  r_poly;
    logic [7:0]                  r_init;
    logic [crc8r_pkg::POS_W-1:0] r_pos;
    logic [crc8r_pkg::POS_W-1:0] n_pos;
    logic [7:0]                  r_crc;
    logic [7:0]                  n_crc;
    logic [7:0]                  r_fail;
    logic [7:0]                  n_fail;
    logic                        r_bank;
    logic                        n_bank;
    logic [1:0]                  r_outstanding;
    logic [1:0]                  n_outstanding;

    logic                        hunting;
    logic                        in_payload;
    logic                        accept;
    logic                        good_push;
    logic [crc8r_pkg::POS_W-1:0] pos_m1;

    assign hunting    = (r_pos == '0) || (r_pos > POS_CRC);
    assign in_payload = !hunting && (r_pos != POS_CRC);
    assign o_rx_ready = !i_fifo_full && !(in_payload && (r_outstanding == 2'd2));
    assign accept     = i_rx_valid && o_rx_ready;
    assign pos_m1     = r_pos - 1'b1;

    assign o_ram_wr_en   = accept && in_payload;
    assign o_ram_wr_addr = {r_bank, pos_m1[crc8r_pkg::IDX_W-1:0]};
    assign o_ram_wr_data = i_rx_byte;
    assign o_push        = accept;

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_fail    = r_fail;
        n_bank    = r_bank;
        good_push = 1'b0;
        o_push_cmd.kind = crc8r_pkg::KIND_TAKEN;
        if (hunting) begin
            n_pos = '0;
            if (i_rx_byte == r_start_byte) begin
                n_pos = crc8r_pkg::POS_W'(1);
                n_crc = r_init;
            end else begin
                o_push_cmd.kind = crc8r_pkg::KIND_REJECT;
            end
        end else if (in_payload) begin
            n_pos = r_pos + 1'b1;
            n_crc = crc8r_pkg::crc8_fold(r_crc, i_rx_byte, r_poly);
        end else begin
            n_pos = '0;
            n_crc = r_init;
            if (i_rx_byte == r_crc) begin
                n_fail          = '0;
                n_bank          = !r_bank;
                good_push       = 1'b1;
                o_push_cmd.kind = crc8r_pkg::KIND_GOOD;
            end else begin
                if (r_fail != 8'hFF) begin
                    n_fail = r_fail + 1'b1;
                end
                o_push_cmd.kind = crc8r_pkg::KIND_FAIL;
            end
        end
        o_push_cmd.fail_total = n_fail;
        o_push_cmd.bank       = r_bank;
    end

    always_comb begin
        n_outstanding = r_outstanding;
        unique case ({accept && good_push, i_burst_done})
            2'b10:   n_outstanding = r_outstanding + 1'b1;
            2'b01:   n_outstanding = r_outstanding - 1'b1;
            default: n_outstanding = r_outstanding;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= 8'd126;
            r_poly        <= 8'd7;
            r_init        <= 8'd0;
            r_pos         <= '0;
            r_crc         <= 8'd0;
            r_fail        <= '0;
            r_bank        <= 1'b0;
            r_outstanding <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (crc8r_pkg::t_cfg_index'(i_cfg_index))
                    crc8r_pkg::CFG_START: r_start_byte <= i_cfg_data;
                    crc8r_pkg::CFG_POLY:  r_poly       <= i_cfg_data;
                    crc8r_pkg::CFG_INIT:  r_init       <= i_cfg_data;
                    default:              r_start_byte <= r_start_byte;
                endcase
            end
            if (accept) begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_fail <= n_fail;
                r_bank <= n_bank;
            end
            r_outstanding <= n_outstanding;
        end
    end

    a_outstanding_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= 2'd2) else $error("more than two payload banks pending");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_wr_en |-> (r_outstanding != 2'd2))
        else $error("payload write into bank still being read");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CRC) else $error("frame position out of range");

endmodule

>>> sv/crc8r_back.sv
// Back end: pops commands, expands good frames into payload bursts read
// from the store, registered result output. Depends on crc8r_pkg.
module crc8r_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  crc8r_pkg::t_cmd              i_head,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_ram_rd_en,
    output logic [crc8r_pkg::RAM_AW-1:0] o_ram_rd_addr,
    input  logic [7:0]                   i_ram_rd_data,
    output logic                         o_burst_done,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [1:0]                   o_kind,
    output logic [5:0]                   o_byte_index,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_last,
    output logic [7:0]                   o_failure_total
);

    localparam logic [crc8r_pkg::IDX_W-1:0] IDX_LAST =
        crc8r_pkg::IDX_W'(crc8r_pkg::PAYLOAD_LEN - 1);

    crc8r_pkg::t_back_state        r_state;
    crc8r_pkg::t_back_state        n_state;
    logic [crc8r_pkg::IDX_W-1:0]   r_idx;
    logic [crc8r_pkg::IDX_W-1:0]   n_idx;
    logic [7:0]                    r_fail;
    logic                          r_bank;

    logic                          r_a_valid;
    crc8r_pkg::t_kind              r_a_kind;
    logic [crc8r_pkg::IDX_W-1:0]   r_a_idx;
    logic                          r_a_last;
    logic [7:0]                    r_a_fail;
    logic                          r_a_ram;

    logic                          r_out_valid;
    logic [1:0]                    r_out_kind;
    logic [5:0]                    r_out_idx;
    logic [7:0]                    r_out_data;
    logic                          r_out_last;
    logic [7:0]                    r_out_fail;

    logic                          out_free;
    logic                          a_adv;
    logic                          can_issue;
    logic                          in_burst;
    logic                          issue;
    logic                          issue_good;
    logic [crc8r_pkg::IDX_W-1:0]   issue_idx;
    logic                          issue_last;
    logic                          issue_bank;
    crc8r_pkg::t_kind              issue_kind;
    logic [7:0]                    issue_fail;

    assign out_free  = !r_out_valid || i_res_ready;
    assign a_adv     = r_a_valid && out_free;
    assign can_issue = !r_a_valid || out_free;
    assign in_burst  = (r_state == crc8r_pkg::BK_BURST);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_pop      = 1'b0;
        issue      = 1'b0;
        issue_good = in_burst;
        issue_idx  = '0;
        issue_bank = i_head.bank;
        issue_kind = i_head.kind;
        issue_fail = i_head.fail_total;
        unique case (r_state)
            crc8r_pkg::BK_IDLE: begin
                if (can_issue && !i_empty) begin
                    o_pop      = 1'b1;
                    issue      = 1'b1;
                    issue_good = (i_head.kind == crc8r_pkg::KIND_GOOD);
                    if (issue_good && (IDX_LAST != '0)) begin
                        n_state = crc8r_pkg::BK_BURST;
                        n_idx   = crc8r_pkg::IDX_W'(1);
                    end
                end
            end
            crc8r_pkg::BK_BURST: begin
                issue_idx  = r_idx;
                issue_bank = r_bank;
                issue_kind = crc8r_pkg::KIND_GOOD;
                issue_fail = r_fail;
                if (can_issue) begin
                    issue = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_state = crc8r_pkg::BK_IDLE;
                    end
                end
            end
            default: n_state = crc8r_pkg::BK_IDLE;
        endcase
        issue_last = !issue_good || (issue_idx == IDX_LAST);
    end

    assign o_ram_rd_en   = issue && issue_good;
    assign o_ram_rd_addr = {issue_bank, issue_idx};
    assign o_burst_done  = issue && issue_good && (issue_idx == IDX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crc8r_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_fail <= i_head.fail_total;
            r_bank <= i_head.bank;
        end
        if (issue) begin
            r_a_kind <= issue_kind;
            r_a_idx  <= issue_good ? issue_idx : '0;
            r_a_last <= issue_last;
            r_a_fail <= issue_fail;
            r_a_ram  <= issue_good;
        end
        if (a_adv) begin
            r_out_kind <= r_a_kind;
            r_out_idx  <= 6'(r_a_idx);
            r_out_data <= r_a_ram ? i_ram_rd_data : 8'd0;
            r_out_last <= r_a_last;
            r_out_fail <= r_a_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_byte_index    = r_out_idx;
    assign o_payload_byte  = r_out_data;
    assign o_last          = r_out_last;
    assign o_failure_total = r_out_fail;

    a_burst_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_ram && r_a_last) |-> (r_a_idx == IDX_LAST))
        else $error("burst ended at wrong index");
    a_burst_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_ram) |-> (r_a_kind == crc8r_pkg::KIND_GOOD))
        else $error("store read for non-payload result");
    a_no_pop_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_burst |-> !o_pop) else $error("command popped during burst");

endmodule

>>> sv/crc8_checked_frame_receiver.sv
// Start-of-frame receiver with CRC-8 check: top level.
// Instantiates crc8r_front, crc8r_cmd_fifo, crc8r_back, crc8r_ram; uses crc8r_pkg.
//
// Input channel (i_rx_valid/o_rx_ready/i_rx_byte) takes one serial byte per
// transaction. While hunting, bytes other than the start byte give a reject
// result; after the start byte PAYLOAD_LEN payload bytes are stored and
// folded into the CRC, and the next byte is checked against it. Each byte
// gives one result, except a good CRC byte, which gives PAYLOAD_LEN payload
// results, the final one with o_last set.
// Config channel (i_cfg_valid/o_cfg_ready) is always ready; index 0 start
// byte, 1 polynomial, 2 CRC initial value; other indexes are ignored.
// Throughput: one input byte per cycle while o_rx_ready is high; results
// leave at one per cycle while i_res_ready is high.
// The payload store holds two frames; the front also stalls a payload byte
// while bursts of both banks are still pending. A four-entry command queue
// separates input from output, so a stalled receiver backs up the input
// once the queue fills or both banks are pending.
// Reset (synchronous, active low) returns to hunting, clears the failure
// count and loads register defaults; the payload store is not cleared.
module crc8_checked_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_kind,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    output logic [7:0] o_failure_total
);

    logic                         ram_wr_en;
    logic [crc8r_pkg::RAM_AW-1:0] ram_wr_addr;
    logic [7:0]                   ram_wr_data;
    logic                         ram_rd_en;
    logic [crc8r_pkg::RAM_AW-1:0] ram_rd_addr;
    logic [7:0]                   ram_rd_data;
    logic                         push;
    crc8r_pkg::t_cmd              push_cmd;
    logic                         fifo_full;
    logic                         pop;
    crc8r_pkg::t_cmd              head;
    logic                         fifo_empty;
    logic                         burst_done;

    assign o_cfg_ready = 1'b1;

    crc8r_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_push        (push),
        .o_push_cmd    (push_cmd),
        .i_fifo_full   (fifo_full),
        .i_burst_done  (burst_done)
    );

    crc8r_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (fifo_full),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (fifo_empty)
    );

    crc8r_ram #(
        .WIDTH (8),
        .DEPTH (crc8r_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    crc8r_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (fifo_empty),
        .o_pop           (pop),
        .o_ram_rd_en     (ram_rd_en),
        .o_ram_rd_addr   (ram_rd_addr),
        .i_ram_rd_data   (ram_rd_data),
        .o_burst_done    (burst_done),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_kind          (o_kind),
        .o_byte_index    (o_byte_index),
        .o_payload_byte  (o_payload_byte),
        .o_last          (o_last),
        .o_failure_total (o_failure_total)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for crc8_checked_frame_receiver: sends framed serial bytes,
// predicts every result with an internal receiver model and compares them in order.
// Depends on crc8r_pkg and the receiver RTL.
module testbench;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         RANDOM_ITEMS = 8;

    typedef struct {
        crc8r_pkg::t_kind kind;
        logic [5:0]       index;
        logic [7:0]       data;
        logic             last;
        logic [7:0]       fails;
    } t_frame_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_data = 8'd0;
    logic       i_rx_valid = 1'b0;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte = 8'd0;
    logic       o_res_valid;
    logic       i_res_ready = 1'b0;
    logic [1:0] o_kind;
    logic [5:0] o_byte_index;
    logic [7:0] o_payload_byte;
    logic       o_last;
    logic [7:0] o_failure_total;

    // receiver model state
    logic [7:0] cfg_start_byte = 8'h7E;
    logic [7:0] cfg_poly = 8'h07;
    logic [7:0] cfg_crc_init = 8'h00;
    logic [6:0] frame_pos = 7'd0;
    logic [7:0] crc_run = 8'h00;
    logic [7:0] payload_mem [crc8r_pkg::PAYLOAD_LEN];
    logic [7:0] fail_cnt = 8'd0;

    t_frame_result pending_results[$];
    int  fault_count = 0;
    int  sent_count = 0;
    int  quiet_cycles = 0;
    int  ready_hold = 0;
    bit  idle_en = 1'b1;

    crc8_checked_frame_receiver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_kind         (o_kind),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .o_failure_total(o_failure_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bit-serial CRC-8, MSB first
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data,
                                              input logic [7:0] poly);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ poly;
            end
        end
        return r;
    endfunction

    task automatic apply_reg_write(input logic [1:0] idx, input logic [7:0] value);
        case (idx)
            crc8r_pkg::CFG_START: cfg_start_byte = value;
            crc8r_pkg::CFG_POLY:  cfg_poly = value;
            crc8r_pkg::CFG_INIT:  cfg_crc_init = value;
            default: ;
        endcase
    endtask

    task automatic track_rx_byte(input logic [7:0] b);
        t_frame_result r;
        r.kind  = crc8r_pkg::KIND_TAKEN;
        r.index = 6'd0;
        r.data  = 8'd0;
        r.last  = 1'b1;
        if (frame_pos == 0) begin
            if (b == cfg_start_byte) begin
                frame_pos = 7'd1;
                crc_run   = cfg_crc_init;
            end else begin
                r.kind = crc8r_pkg::KIND_REJECT;
            end
            r.fails = fail_cnt;
            pending_results.push_back(r);
        end else if (frame_pos <= crc8r_pkg::PAYLOAD_LEN) begin
            payload_mem[frame_pos - 1] = b;
            crc_run   = crc_update(crc_run, b, cfg_poly);
            frame_pos = frame_pos + 7'd1;
            r.fails   = fail_cnt;
            pending_results.push_back(r);
        end else begin
            frame_pos = 7'd0;
            if (b == crc_run) begin
                fail_cnt = 8'd0;
                for (int i = 0; i < crc8r_pkg::PAYLOAD_LEN; i++) begin
                    r.kind  = crc8r_pkg::KIND_GOOD;
                    r.index = 6'(i);
                    r.data  = payload_mem[i];
                    r.last  = (i == crc8r_pkg::PAYLOAD_LEN - 1);
                    r.fails = fail_cnt;
                    pending_results.push_back(r);
                end
            end else begin
                if (fail_cnt != 8'hFF) begin
                    fail_cnt = fail_cnt + 8'd1;
                end
                r.kind  = crc8r_pkg::KIND_FAIL;
                r.fails = fail_cnt;
                pending_results.push_back(r);
            end
            crc_run = cfg_crc_init;
        end
    endtask

    // one byte transaction on the rx channel, with an optional random gap before it
    task automatic send_rx(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        track_rx_byte(b);
        sent_count++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg_write(idx, value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_rx_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // finishes any open frame, then sends start, payload and a good or corrupted CRC
    task automatic send_frame(input bit good, input bit edge_bytes);
        logic [7:0] c;
        logic [7:0] b;
        while (frame_pos != 0) send_rx(8'($urandom_range(0, 255)));
        send_rx(cfg_start_byte);
        c = cfg_crc_init;
        for (int i = 0; i < crc8r_pkg::PAYLOAD_LEN; i++) begin
            b = 8'($urandom_range(0, 255));
            if (edge_bytes && i == 0) b = 8'h00;
            if (edge_bytes && i == 1) b = 8'hFF;
            if (edge_bytes && i == 2) b = cfg_start_byte;
            send_rx(b);
            c = crc_update(c, b, cfg_poly);
        end
        send_rx(good ? c : c ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic test_hunting_rejects();
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h7F);
        send_rx(8'h7D);
        send_rx(8'h80);
        send_rx(8'h01);
    endtask

    task automatic test_crc_failure();
        send_frame(1'b0, 1'b1);
    endtask

    task automatic test_register_sweep();
        wait_idle();
        cfg_write(crc8r_pkg::CFG_START, 8'hA5);
        cfg_write(crc8r_pkg::CFG_POLY, 8'h31);
        cfg_write(crc8r_pkg::CFG_INIT, 8'($urandom_range(0, 255)));
        cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
        send_rx(8'h7E);
        send_rx(8'($urandom_range(0, 255)));
    endtask

    // a new CRC seed written mid-frame must only apply from the next start byte
    task automatic test_crc_initial_midframe();
        logic [7:0] c;
        logic [7:0] b;
        while (frame_pos != 0) send_rx(8'($urandom_range(0, 255)));
        send_rx(cfg_start_byte);
        c = cfg_crc_init;
        for (int i = 0; i < crc8r_pkg::PAYLOAD_LEN; i++) begin
            if (i == crc8r_pkg::PAYLOAD_LEN / 2) begin
                wait_idle();
                cfg_write(crc8r_pkg::CFG_INIT, ~cfg_crc_init);
            end
            b = 8'($urandom_range(0, 255));
            send_rx(b);
            c = crc_update(c, b, cfg_poly);
        end
        send_rx(c);
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_ITEMS) send_rx(8'($urandom_range(0, 255)));
    endtask

    // default registers, no idling on either side
    task automatic test_default_frame();
        wait_idle();
        cfg_write(crc8r_pkg::CFG_START, 8'h7E);
        cfg_write(crc8r_pkg::CFG_POLY, 8'h07);
        cfg_write(crc8r_pkg::CFG_INIT, 8'h00);
        idle_en = 1'b0;
        send_frame(1'b1, 1'b1);
    endtask

    // result sink with random stall bursts
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold  <= ready_hold - 1;
            i_res_ready <= (ready_hold == 1);
        end else if (idle_en && i_rst_n && $urandom_range(0, 11) == 0) begin
            ready_hold  <= $urandom_range(1, 18);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result kind=%0d idx=%0d byte=%02h last=%0b fails=%0d",
                         $time, o_kind, o_byte_index, o_payload_byte, o_last,
                         o_failure_total);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_kind !== exp_r.kind || o_byte_index !== exp_r.index
                        || o_payload_byte !== exp_r.data || o_last !== exp_r.last
                        || o_failure_total !== exp_r.fails) begin
                    fault_count++;
                    $display("%0t: expected kind=%0d idx=%0d byte=%02h last=%0b fails=%0d",
                             $time, exp_r.kind, exp_r.index, exp_r.data, exp_r.last,
                             exp_r.fails);
                    $display("%0t: actual   kind=%0d idx=%0d byte=%02h last=%0b fails=%0d",
                             $time, o_kind, o_byte_index, o_payload_byte, o_last,
                             o_failure_total);
                end
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hunting_rejects();
        test_crc_failure();
        test_register_sweep();
        test_crc_initial_midframe();
        test_random_traffic();
        test_default_frame();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/crc8r_pkg.sv
sv/crc8r_ram.sv
sv/crc8r_cmd_fifo.sv
sv/crc8r_front.sv
sv/crc8r_back.sv
sv/crc8_checked_frame_receiver.sv
tb/testbench.sv
